// File: sv/rrlus_pkg.sv
`timescale 1ns / 1ps
package rrlus_pkg;
	localparam int RowCount = 4096;
	localparam int MaxRuns = 8;
	localparam int RowBits = $clog2(RowCount);
	localparam int SlotBits = $clog2(MaxRuns);
	localparam int CntBits = $clog2(MaxRuns + 1);
	localparam int RunAddrBits = RowBits + SlotBits;

	localparam logic [1:0] ReqInsert = 2'd0;
	localparam logic [1:0] ReqRemove = 2'd1;

	localparam logic [1:0] StDone = 2'd0;
	localparam logic [1:0] StIgnored = 2'd1;
	localparam logic [1:0] StFull = 2'd2;

	localparam logic [2:0] RegXLow = 3'd0;
	localparam logic [2:0] RegXHigh = 3'd1;
	localparam logic [2:0] RegYLow = 3'd2;
	localparam logic [2:0] RegYHigh = 3'd3;
	localparam logic [2:0] RegZLow = 3'd4;
	localparam logic [2:0] RegZHigh = 3'd5;
endpackage

// File: sv/rrlus_ram.sv
`timescale 1ns / 1ps
module rrlus_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: sv/row_run_list_union_subtract.sv
`timescale 1ns / 1ps
// Keeps one sorted list of x runs (inclusive start, exclusive end) per (y,z) row and
// applies insert (union), remove (subtract) and read requests. A row that lies in the
// extent is handled in the following way: S_INDEX resolves the row index, the row's run
// count is read from a count memory, a change request then reads every stored run of the
// row in turn from the run memory, each through S_RDRUN and S_FOLD, and folds it into a
// local list, and the new list is written back one run per cycle; a read request reads
// at most the run in its slot. A change that cannot fit is dropped with status row full,
// a request on a row outside the extent returns status ignored, and a reversed span or a
// remove on an empty row leaves the row as it is. The next request is taken in the cycle
// after the result is accepted. After reset the block clears every entry of the count
// memory before it takes its first request; configuration writes are taken during that
// time. Runs that only touch a span stay separate, a remove strictly inside a run of a
// full row is dropped with status row full, and a remove that covers the whole x extent
// clears the row.
module row_run_list_union_subtract (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata: req_type[1:0], row_y[16:2], row_z[31:17], span_first[46:32],
	// span_last[61:47], run_slot[64:62], zero fill to 72 bits
	input  logic [71:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata: status[1:0], runs_in_row[5:2], run_valid[6], run_start[21:7],
	// run_stop[37:22], zero fill to 40 bits
	output logic [39:0] m_tdata,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [14:0] cfg_data
);
	localparam int RB = rrlus_pkg::RowBits;
	localparam int SB = rrlus_pkg::SlotBits;
	localparam int CB = rrlus_pkg::CntBits;
	localparam int NR = rrlus_pkg::MaxRuns;

	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_INDEX = 9'b000000100,
		S_CNT   = 9'b000001000,
		S_RDRUN = 9'b000010000,
		S_FOLD  = 9'b000100000,
		S_DECIDE= 9'b001000000,
		S_WRITE = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	state_t state_q;
	logic signed [14:0] xl_q, xh_q, yl_q, yh_q, zl_q, zh_q;
	logic [1:0]         req_q;
	logic signed [14:0] y_q, z_q, r1_q, r2_q;
	logic [2:0]         slot_q;
	logic [RB-1:0]      row_q, clr_q;
	logic [CB-1:0]      n_q, k_q, m_q;
	logic signed [15:0] nb_q [NR+2];
	logic signed [16:0] ne_q [NR+2];
	logic signed [16:0] mb_q, me_q;
	logic               merged_q;
	logic [1:0]         st_q;
	logic [CB-1:0]      cnt_out_q;
	logic               vld_q;
	logic [14:0]        rs_q;
	logic [15:0]        re_q;
	logic               ovr_q;

	// count memory
	logic          cnt_we;
	logic [RB-1:0] cnt_waddr;
	logic [CB-1:0] cnt_wdata, cnt_rdata;
	// run memory
	logic                          run_we;
	logic [rrlus_pkg::RunAddrBits-1:0] run_addr;
	logic [30:0]                   run_wdata, run_rdata;

	// row index: one multiply, registered in S_INDEX
	logic signed [16:0] dy, dz, ydim;
	logic signed [34:0] row_full;
	assign dy = 17'(y_q) - 17'(yl_q);
	assign dz = 17'(z_q) - 17'(zl_q);
	assign ydim = 17'(yh_q) - 17'(yl_q) + 17'sd1;
	assign row_full = 35'(dz) * 35'(ydim) + 35'(dy);

	// The count read is issued from the freshly computed index during S_INDEX, so its
	// data is ready in S_CNT.
	rrlus_ram #(.Width(CB), .Depth(rrlus_pkg::RowCount)) u_cnt (
		.clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.raddr(row_full[RB-1:0]), .rdata(cnt_rdata));
	rrlus_ram #(.Width(31), .Depth(rrlus_pkg::RowCount * NR)) u_run (
		.clk(clk), .we(run_we), .waddr(run_addr), .wdata(run_wdata),
		.raddr(run_addr), .rdata(run_rdata));

	logic in_ext;
	assign in_ext = (y_q >= yl_q) && (y_q <= yh_q) && (z_q >= zl_q) && (z_q <= zh_q);

	// one stored run, sign extended
	logic signed [16:0] rb, re, r1e, r2e;
	assign rb = 17'(signed'(run_rdata[14:0]));
	assign re = 17'(signed'(run_rdata[30:15]));
	assign r1e = 17'(r1_q);
	assign r2e = 17'(r2_q);

	logic [SB-1:0] kidx;
	assign kidx = k_q[SB-1:0];

	always_comb begin
		cnt_we = 1'b0;
		cnt_waddr = row_q;
		cnt_wdata = m_q;
		if (state_q == S_CLEAR) begin
			cnt_we = 1'b1;
			cnt_waddr = clr_q;
			cnt_wdata = '0;
		end else if (state_q == S_WRITE && k_q == m_q) begin
			cnt_we = 1'b1;
		end
		run_we = (state_q == S_WRITE) && (k_q < m_q);
		run_addr = {row_q, kidx};
		run_wdata = {ne_q[kidx][15:0], nb_q[kidx][14:0]};
	end

	assign s_tready = (state_q == S_IDLE) && !m_tvalid;
	assign m_tdata = {2'b0, re_q, rs_q, vld_q, cnt_out_q, st_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xl_q <= '0; xh_q <= '1; yl_q <= '0; yh_q <= '1; zl_q <= '0; zh_q <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				rrlus_pkg::RegXLow:  xl_q <= cfg_data;
				rrlus_pkg::RegXHigh: xh_q <= cfg_data;
				rrlus_pkg::RegYLow:  yl_q <= cfg_data;
				rrlus_pkg::RegYHigh: yh_q <= cfg_data;
				rrlus_pkg::RegZLow:  zl_q <= cfg_data;
				rrlus_pkg::RegZHigh: zh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == RB'(rrlus_pkg::RowCount - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid && s_tready) begin
						req_q <= s_tdata[1:0];
						y_q <= s_tdata[16:2];
						z_q <= s_tdata[31:17];
						r1_q <= s_tdata[46:32];
						r2_q <= s_tdata[61:47];
						slot_q <= s_tdata[64:62];
						state_q <= S_INDEX;
					end
				end
				S_INDEX: begin
					row_q <= row_full[RB-1:0];
					st_q <= rrlus_pkg::StDone;
					cnt_out_q <= '0; vld_q <= 1'b0; rs_q <= '0; re_q <= '0;
					if (!in_ext || row_full < 35'sd0 ||
					    row_full >= 35'(rrlus_pkg::RowCount)) begin
						st_q <= rrlus_pkg::StIgnored;
						state_q <= S_OUT;
					end else begin
						state_q <= S_CNT;
					end
				end
				S_CNT: begin
					// count memory read data is valid now
					n_q <= (cnt_rdata > CB'(NR)) ? CB'(NR) : cnt_rdata;
					cnt_out_q <= (cnt_rdata > CB'(NR)) ? CB'(NR) : cnt_rdata;
					k_q <= '0; m_q <= '0;
					mb_q <= r1e; me_q <= r2e + 17'sd1; merged_q <= 1'b0; ovr_q <= 1'b0;
					state_q <= S_RDRUN;
					if (req_q[1]) begin
						if (CB'(slot_q) >= cnt_rdata) state_q <= S_OUT;
						else k_q <= CB'(slot_q);
					end else if (r1_q > r2_q) begin
						state_q <= S_OUT;
					end else if (req_q == rrlus_pkg::ReqRemove) begin
						if (cnt_rdata == '0) begin
							state_q <= S_OUT;
						end else if (r1_q <= xl_q && r2_q >= xh_q) begin
							m_q <= '0; k_q <= '0; cnt_out_q <= '0;
							state_q <= S_WRITE;
						end
					end else if (cnt_rdata == '0) begin
						state_q <= S_DECIDE;
					end
				end
				S_RDRUN: state_q <= S_FOLD;
				S_FOLD: begin
					if (req_q[1]) begin
						vld_q <= 1'b1; rs_q <= run_rdata[14:0]; re_q <= run_rdata[30:15];
						state_q <= S_OUT;
					end else begin
						if (req_q == rrlus_pkg::ReqInsert) begin
							if (re <= r1e) begin
								nb_q[m_q] <= rb[15:0]; ne_q[m_q] <= re; m_q <= m_q + 1'b1;
							end else if (rb > r2e) begin
								if (!merged_q) begin
									nb_q[m_q] <= mb_q[15:0]; ne_q[m_q] <= me_q;
									nb_q[m_q + 1'b1] <= rb[15:0]; ne_q[m_q + 1'b1] <= re;
									m_q <= m_q + 2'd2; merged_q <= 1'b1;
								end else begin
									nb_q[m_q] <= rb[15:0]; ne_q[m_q] <= re; m_q <= m_q + 1'b1;
								end
							end else begin
								if (rb < mb_q) mb_q <= rb;
								if (re > me_q) me_q <= re;
							end
						end else begin
							if (re <= r1e || rb > r2e) begin
								nb_q[m_q] <= rb[15:0]; ne_q[m_q] <= re; m_q <= m_q + 1'b1;
							end else if (rb < r1e && r2e + 17'sd1 < re) begin
								nb_q[m_q] <= rb[15:0]; ne_q[m_q] <= r1e;
								nb_q[m_q + 1'b1] <= 16'(r2e + 17'sd1); ne_q[m_q + 1'b1] <= re;
								m_q <= m_q + 2'd2;
								// A split adds one run; in a full row that cannot fit.
								if (n_q == CB'(NR)) ovr_q <= 1'b1;
							end else if (rb < r1e) begin
								nb_q[m_q] <= rb[15:0]; ne_q[m_q] <= r1e; m_q <= m_q + 1'b1;
							end else if (r2e + 17'sd1 < re) begin
								nb_q[m_q] <= 16'(r2e + 17'sd1); ne_q[m_q] <= re;
								m_q <= m_q + 1'b1;
							end
						end
						k_q <= k_q + 1'b1;
						state_q <= (k_q + 1'b1 == n_q) ? S_DECIDE : S_RDRUN;
					end
				end
				S_DECIDE: begin
					if (req_q == rrlus_pkg::ReqInsert && !merged_q) begin
						if (m_q == CB'(NR)) begin
							st_q <= rrlus_pkg::StFull;
							state_q <= S_OUT;
						end else begin
							nb_q[m_q] <= mb_q[15:0]; ne_q[m_q] <= me_q;
							m_q <= m_q + 1'b1; cnt_out_q <= m_q + 1'b1;
							k_q <= '0; state_q <= S_WRITE;
						end
					end else if (ovr_q || m_q > CB'(NR)) begin
						st_q <= rrlus_pkg::StFull;
						state_q <= S_OUT;
					end else begin
						cnt_out_q <= m_q; k_q <= '0; state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					k_q <= k_q + 1'b1;
					if (k_q == m_q) state_q <= S_OUT;
				end
				S_OUT: begin
					if (!m_tvalid) begin
						m_tvalid <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The input side stays closed while a request is in work or a result waits.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !s_tready) else $error("accept while busy");
	// The write-back never lists more runs than a row can hold.
	a_wb_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE) |-> (m_q <= CB'(NR))) else $error("write-back overflow");
	// A result is raised only when leaving the output state.
	a_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_OUT)) else $error("stray result");
endmodule
